// ===== hdl/voxel_face_extractor_core_macros.svh =====
// Assertion macros used by the voxel face extractor core.
`ifndef VOXEL_FACE_EXTRACTOR_CORE_MACROS_SVH
`define VOXEL_FACE_EXTRACTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check that pre implies post in the same cycle.
`define VFE_CHECK_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("voxel face extractor check failed");
// Check that pre implies post in the next cycle.
`define VFE_CHECK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("voxel face extractor check failed");
`else
`define VFE_CHECK_NOW(lbl, pre, post)
`define VFE_CHECK_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/vfe_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package vfe_pkg;

    localparam int MAX_DIM_DEF = 32;
    localparam int CFG_IDX_W   = 3;

    localparam logic [5:0] SIZE_RESET = 6'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOLID_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd3;

    // axis codes
    localparam logic [1:0] AX_X    = 2'd0;
    localparam logic [1:0] AX_Y    = 2'd1;
    localparam logic [1:0] AX_Z    = 2'd2;
    localparam logic [1:0] AX_NONE = 2'd3;

    // which cell a memory probe looks at
    typedef enum logic [2:0] {
        TAG_C    = 3'd0,
        TAG_NY   = 3'd1,
        TAG_NX   = 3'd2,
        TAG_NZ   = 3'd3,
        TAG_SCAN = 3'd4
    } t_tag;

    // scan position update
    typedef enum logic [2:0] {
        T_HOLD = 3'd0,
        T_TOP  = 3'd1,
        T_ZERO = 3'd2,
        T_DEC  = 3'd3,
        T_INC  = 3'd4
    } t_top;

    typedef struct packed {
        logic issue;
        t_tag tag;
        t_top t_op;
        logic capture;
        logic set_hi;
        logic set_lo;
        logic build_hollow;
        logic build_solid;
        logic emit;
        logic load_wr;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic p_hit;
        logic t_zero;
        logic clr_last;
        logic is_load;
        logic is_solid;
        logic axis_ok;
        logic last_face;
    } t_stat;

endpackage

// ===== hdl/vfe_datapath.sv =====
// Datapath: configuration, occupancy row memory, probes, scan position and result register.
`timescale 1ns / 1ps
module vfe_datapath #(
    parameter int MAX_DIM = vfe_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vfe_pkg::t_cmd                  i_cmd,
    output vfe_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_we,
    input  logic [vfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [5:0]                     i_cfg_data,
    input  logic                           i_mode,
    input  logic [1:0]                     i_axis,
    input  logic [5:0]                     i_pos_x,
    input  logic [5:0]                     i_pos_y,
    input  logic [5:0]                     i_pos_z,
    input  logic                           i_fill,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic                           o_face_present,
    output logic [1:0]                     o_face_axis,
    output logic                           o_face_side,
    output logic [5:0]                     o_corner_x,
    output logic [5:0]                     o_corner_y,
    output logic [5:0]                     o_corner_z,
    output logic                           o_last
);
    import vfe_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_DIM);

    function automatic logic [5:0] eff_size(input logic [5:0] v);
        logic [5:0] e;
        if (v == 6'd0) begin
            e = 6'd1;
        end else if (int'(v) > MAX_DIM) begin
            e = 6'(MAX_DIM);
        end else begin
            e = v;
        end
        return e;
    endfunction

    // configuration
    logic       r_solid_mode;
    logic [5:0] r_size_x, r_size_y, r_size_z;

    // captured item
    logic       r_mode, r_fill, r_kind_solid;
    logic [1:0] r_axis;
    logic [5:0] r_x, r_y, r_z;

    // scan and probe state
    logic [5:0]    r_t, r_hi, r_lo, r_p_t;
    logic          r_p_valid, r_p_in;
    t_tag          r_p_tag;
    logic [CW-1:0] r_p_bit;
    logic [MAX_DIM-1:0] r_row;
    logic          r_c, r_ny, r_nx, r_nz;
    logic [2:0]    r_pend;
    logic [AW-1:0] r_clr;

    logic [MAX_DIM-1:0] mem [DEPTH];

    logic [5:0] eff_x, eff_y, eff_z, scan_len;
    logic [5:0] px, py, pz;
    logic       neg_x, neg_y, neg_z, p_in;
    logic [AW-1:0] rd_addr, r_p_addr, wr_addr;
    logic [MAX_DIM-1:0] wr_data, bit_mask;
    logic       wr_en, cell_val;
    logic [2:0] pick, rest;
    logic       e_present, e_side;
    logic [1:0] e_axis;
    logic [5:0] e_x, e_y, e_z, e_t;

    assign eff_x = eff_size(r_size_x);
    assign eff_y = eff_size(r_size_y);
    assign eff_z = eff_size(r_size_z);

    always_comb begin
        case (r_axis)
            AX_X:    scan_len = eff_x;
            AX_Y:    scan_len = eff_y;
            default: scan_len = eff_z;
        endcase
    end

    // probe coordinates; a decrement below zero leaves the grid
    always_comb begin
        px = r_x;
        py = r_y;
        pz = r_z;
        neg_x = 1'b0;
        neg_y = 1'b0;
        neg_z = 1'b0;
        case (i_cmd.tag)
            TAG_NY: begin
                py = r_y - 6'd1;
                neg_y = (r_y == 6'd0);
            end
            TAG_NX: begin
                px = r_x - 6'd1;
                neg_x = (r_x == 6'd0);
            end
            TAG_NZ: begin
                pz = r_z - 6'd1;
                neg_z = (r_z == 6'd0);
            end
            TAG_SCAN: begin
                case (r_axis)
                    AX_X:    px = r_t;
                    AX_Y:    py = r_t;
                    default: pz = r_t;
                endcase
            end
            default: begin
            end
        endcase
        p_in = !neg_x && !neg_y && !neg_z && (px < eff_x) && (py < eff_y) && (pz < eff_z);
        rd_addr = AW'(py) + AW'(pz) * AW'(MAX_DIM);
    end

    assign cell_val = r_p_in & r_row[r_p_bit];

    // memory write: clearing pass or read-modify-write of one row
    assign bit_mask = MAX_DIM'(1) << r_p_bit;
    always_comb begin
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = '0;
        end else begin
            wr_en   = i_cmd.load_wr & r_p_in;
            wr_addr = r_p_addr;
            wr_data = r_fill ? (r_row | bit_mask) : (r_row & ~bit_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_row <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid_mode <= 1'b0;
            r_size_x     <= SIZE_RESET;
            r_size_y     <= SIZE_RESET;
            r_size_z     <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOLID_MODE: r_solid_mode <= i_cfg_data[0];
                CFG_SIZE_X:     r_size_x     <= i_cfg_data;
                CFG_SIZE_Y:     r_size_y     <= i_cfg_data;
                CFG_SIZE_Z:     r_size_z     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            r_p_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode       <= i_mode;
            r_axis       <= i_axis;
            r_x          <= i_pos_x;
            r_y          <= i_pos_y;
            r_z          <= i_pos_z;
            r_fill       <= i_fill;
            r_kind_solid <= r_solid_mode;
        end
        if (i_cmd.issue) begin
            r_p_tag  <= i_cmd.tag;
            r_p_t    <= r_t;
            r_p_in   <= p_in;
            r_p_bit  <= CW'(px);
            r_p_addr <= rd_addr;
        end
        if (r_p_valid) begin
            case (r_p_tag)
                TAG_C:   r_c  <= cell_val;
                TAG_NY:  r_ny <= cell_val;
                TAG_NX:  r_nx <= cell_val;
                TAG_NZ:  r_nz <= cell_val;
                default: begin
                end
            endcase
        end
        case (i_cmd.t_op)
            T_TOP:   r_t <= scan_len - 6'd1;
            T_ZERO:  r_t <= 6'd0;
            T_DEC:   r_t <= r_t - 6'd1;
            T_INC:   r_t <= r_t + 6'd1;
            default: begin
            end
        endcase
        if (i_cmd.set_hi) begin
            r_hi <= r_p_t;
        end
        if (i_cmd.set_lo) begin
            r_lo <= r_p_t;
        end
    end

    // pending faces: hollow y, x, z in bits 0..2; solid plus, minus in bits 0..1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'b000;
        end else if (i_cmd.capture) begin
            r_pend <= 3'b000;
        end else if (i_cmd.build_hollow) begin
            r_pend <= {r_c != r_nz, r_c != r_nx, r_c != r_ny};
        end else if (i_cmd.build_solid) begin
            r_pend <= 3'b011;
        end else if (i_cmd.emit) begin
            r_pend <= rest;
        end
    end

    always_comb begin
        if (r_pend[0]) begin
            pick = 3'b001;
        end else if (r_pend[1]) begin
            pick = 3'b010;
        end else if (r_pend[2]) begin
            pick = 3'b100;
        end else begin
            pick = 3'b000;
        end
        rest = r_pend & ~pick;
    end

    // format the face picked from the pending set
    always_comb begin
        e_present = (pick != 3'b000);
        e_x  = r_x;
        e_y  = r_y;
        e_z  = r_z;
        e_t  = pick[0] ? (r_hi + 6'd1) : r_lo;
        if (!e_present) begin
            e_axis = AX_X;
            e_side = 1'b0;
            e_x    = 6'd0;
            e_y    = 6'd0;
            e_z    = 6'd0;
        end else if (r_kind_solid) begin
            e_axis = r_axis;
            e_side = ~pick[0];
            case (r_axis)
                AX_X:    e_x = e_t;
                AX_Y:    e_y = e_t;
                default: e_z = e_t;
            endcase
        end else begin
            e_side = r_c;
            if (pick[0]) begin
                e_axis = AX_Y;
            end else if (pick[1]) begin
                e_axis = AX_X;
            end else begin
                e_axis = AX_Z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_face_present <= e_present;
            o_face_axis    <= e_axis;
            o_face_side    <= e_side;
            o_corner_x     <= e_x;
            o_corner_y     <= e_y;
            o_corner_z     <= e_z;
            o_last         <= (rest == 3'b000);
        end
    end

    always_comb begin
        o_stat.out_free  = !o_valid || i_ready;
        o_stat.p_hit     = r_p_valid && (r_p_tag == TAG_SCAN) && cell_val;
        o_stat.t_zero    = (r_t == 6'd0);
        o_stat.clr_last  = (r_clr == AW'(DEPTH - 1));
        o_stat.is_load   = !r_mode;
        o_stat.is_solid  = r_kind_solid;
        o_stat.axis_ok   = (r_axis != AX_NONE);
        o_stat.last_face = (rest == 3'b000);
    end

endmodule

// ===== hdl/vfe_controller.sv =====
// Controller state machine sequencing clear, load, hollow test, column scan and emit.
`timescale 1ns / 1ps
module vfe_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vfe_pkg::t_stat i_stat,
    output vfe_pkg::t_cmd  o_cmd
);
    import vfe_pkg::*;

    typedef enum logic [15:0] {
        S_CLEAR     = 16'h0001,
        S_IDLE      = 16'h0002,
        S_DISPATCH  = 16'h0004,
        S_LOAD_RD   = 16'h0008,
        S_LOAD_WR   = 16'h0010,
        S_H_C       = 16'h0020,
        S_H_NY      = 16'h0040,
        S_H_NX      = 16'h0080,
        S_H_NZ      = 16'h0100,
        S_H_WAIT    = 16'h0200,
        S_H_BUILD   = 16'h0400,
        S_S_INIT    = 16'h0800,
        S_S_HI      = 16'h1000,
        S_S_HI_TAIL = 16'h2000,
        S_S_LO      = 16'h4000,
        S_EMIT      = 16'h8000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.tag  = TAG_C;
        o_cmd.t_op = T_HOLD;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_load) begin
                    n_state = S_LOAD_RD;
                end else if (!i_stat.is_solid) begin
                    n_state = S_H_C;
                end else if (i_stat.axis_ok) begin
                    n_state = S_S_INIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_LOAD_RD: begin
                o_cmd.issue = 1'b1;
                n_state = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                o_cmd.load_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_H_C: begin
                o_cmd.issue = 1'b1;
                n_state = S_H_NY;
            end
            S_H_NY: begin
                o_cmd.issue = 1'b1;
                o_cmd.tag   = TAG_NY;
                n_state = S_H_NX;
            end
            S_H_NX: begin
                o_cmd.issue = 1'b1;
                o_cmd.tag   = TAG_NX;
                n_state = S_H_NZ;
            end
            S_H_NZ: begin
                o_cmd.issue = 1'b1;
                o_cmd.tag   = TAG_NZ;
                n_state = S_H_WAIT;
            end
            S_H_WAIT: begin
                n_state = S_H_BUILD;
            end
            S_H_BUILD: begin
                o_cmd.build_hollow = 1'b1;
                n_state = S_EMIT;
            end
            S_S_INIT: begin
                o_cmd.t_op = T_TOP;
                n_state = S_S_HI;
            end
            S_S_HI: begin
                o_cmd.tag = TAG_SCAN;
                if (i_stat.p_hit) begin
                    o_cmd.set_hi = 1'b1;
                    o_cmd.t_op   = T_ZERO;
                    n_state = S_S_LO;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (i_stat.t_zero) begin
                        n_state = S_S_HI_TAIL;
                    end else begin
                        o_cmd.t_op = T_DEC;
                    end
                end
            end
            S_S_HI_TAIL: begin
                o_cmd.tag = TAG_SCAN;
                if (i_stat.p_hit) begin
                    o_cmd.set_hi = 1'b1;
                    o_cmd.t_op   = T_ZERO;
                    n_state = S_S_LO;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_S_LO: begin
                o_cmd.tag = TAG_SCAN;
                if (i_stat.p_hit) begin
                    o_cmd.set_lo      = 1'b1;
                    o_cmd.build_solid = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.issue = 1'b1;
                    o_cmd.t_op  = T_INC;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_face) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/voxel_face_extractor_core.sv =====
// Voxel face extractor: bit-per-voxel occupancy store with boundary face reporting.
// Load request: dispatch, a row read and a row write precede taking the next request.
// Hollow extract: four row-memory probes (cell, -y, -x, -z neighbours), then 1 to 3 results.
// Solid extract: scans the column down from the top, then up from zero, one probe per cycle
// over len up to MAX_DIM, for a face pair or, on an empty column or unused axis, no face.
// Reset: synchronous, active low; a clearing pass over all MAX_DIM*MAX_DIM rows follows.
`timescale 1ns / 1ps
`include "voxel_face_extractor_core_macros.svh"
module voxel_face_extractor_core #(
    parameter int MAX_DIM = vfe_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [5:0]                    i_cfg_data,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [1:0]                    i_axis,
    input  logic [5:0]                    i_pos_x,
    input  logic [5:0]                    i_pos_y,
    input  logic [5:0]                    i_pos_z,
    input  logic                          i_fill,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_face_present,
    output logic [1:0]                    o_face_axis,
    output logic                          o_face_side,
    output logic [5:0]                    o_corner_x,
    output logic [5:0]                    o_corner_y,
    output logic [5:0]                    o_corner_z,
    output logic                          o_last
);
    import vfe_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Users must change registers only while idle (unenforced); writes are accepted at once.
    assign o_cfg_ready = 1'b1;

    // Sequence each request: clear after reset, then load, hollow test or column scan; for the
    // extracts, finally drain pending faces into the result register one per cycle while it is free.
    vfe_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold the occupancy rows, probe one cell per cycle, and keep the result register,
    // which lets a new request be accepted while the final result still waits.
    vfe_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_axis         (i_axis),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_fill         (i_fill),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_face_present (o_face_present),
        .o_face_axis    (o_face_axis),
        .o_face_side    (o_face_side),
        .o_corner_x     (o_corner_x),
        .o_corner_y     (o_corner_y),
        .o_corner_z     (o_corner_z),
        .o_last         (o_last)
    );

    // A result without a face always closes its request.
    `VFE_CHECK_NOW(a_noface_last, o_valid && !o_face_present, o_last)
    // No result ever names the unused axis code.
    `VFE_CHECK_NOW(a_axis_code, o_valid, o_face_axis != AX_NONE)
    // An accepted request always moves the controller out of idle.
    `VFE_CHECK_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)

endmodule
